>>> hw/rtl/ecr_pkg.sv
// Shared types, widths and helpers for the disc collision resolver.
package ecr_pkg;

    // Packed request and result widths
    localparam int IN_BITS   = 350;
    localparam int IN_TDATA  = 352;
    localparam int OUT_BITS  = 129;
    localparam int OUT_TDATA = 136;

    // Correction lanes: first x, first y, second x, second y
    localparam int LANES     = 4;
    // Quotient bits resolved by the divider, one per stage
    localparam int DIV_STEPS = 41;
    // Divider latency: overflow check, one stage per bit, cap and sign
    localparam int DIV_LAT   = DIV_STEPS + 2;
    // Largest correction magnitude, 2^40
    localparam logic [40:0] QCAP = 41'h100_0000_0000;

    // Input request, first field in the lowest bits
    typedef struct packed {
        logic        [30:0] second_radius;
        logic        [15:0] second_mass;
        logic signed [31:0] second_vel_y;
        logic signed [31:0] second_vel_x;
        logic signed [31:0] second_pos_y;
        logic signed [31:0] second_pos_x;
        logic        [30:0] first_radius;
        logic        [15:0] first_mass;
        logic signed [31:0] first_vel_y;
        logic signed [31:0] first_vel_x;
        logic signed [31:0] first_pos_y;
        logic signed [31:0] first_pos_x;
    } in_t;

    // Result, first field in the lowest bits
    typedef struct packed {
        logic [31:0] new_second_vel_y;
        logic [31:0] new_second_vel_x;
        logic [31:0] new_first_vel_y;
        logic [31:0] new_first_vel_x;
        logic        hit;
    } out_t;

    typedef struct packed {
        logic [31:0] v1x;
        logic [31:0] v1y;
        logic [31:0] v2x;
        logic [31:0] v2y;
    } vel_t;

    // Data that rides alongside the arithmetic
    typedef struct packed {
        vel_t vel;
        logic hit;
    } side_t;

    // Geometry stage results
    typedef struct packed {
        side_t       side;
        logic [66:0] dot;
        logic [65:0] d2;
        logic [32:0] adx;
        logic [32:0] ady;
        logic        dxneg;
        logic        dyneg;
        logic [15:0] m1;
        logic [15:0] m2;
        logic [16:0] total;
    } geom_t;

    // One divider lane: rounded quotient of num / den with sign
    typedef struct packed {
        logic [115:0] num;
        logic [83:0]  den;
        logic         neg;
    } lane_t;

    typedef lane_t [LANES-1:0] lanes_t;

    // Clamp a wide signed value to the 32 bit range
    function automatic logic [31:0] sat32(input logic signed [42:0] v);
        logic [31:0] r;
        if (v > 43'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -43'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/ecr_geom.sv
// Geometry stages: differences, squares, dot product and overlap test.
module ecr_geom (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  ecr_pkg::in_t  in_item,
    output logic          out_valid,
    output ecr_pkg::geom_t out_geom
);

    // Stage 1 registers
    logic               vld1_reg;
    logic signed [32:0] dx_reg, dy_reg, dvx_reg, dvy_reg;
    logic signed [32:0] dx_next, dy_next, dvx_next, dvy_next;
    logic        [31:0] rs_reg, rs_next;
    logic        [16:0] total1_reg, total1_next;
    logic        [15:0] m1_1_reg, m2_1_reg;
    ecr_pkg::vel_t      vel1_reg;

    // Stage 2 registers
    logic               vld2_reg;
    logic        [64:0] sqx_reg, sqy_reg;
    logic signed [65:0] sqx_full, sqy_full;
    logic signed [65:0] pdx_reg, pdy_reg, pdx_next, pdy_next;
    logic        [63:0] rs2_reg, rs2_next;
    logic        [32:0] adx_reg, ady_reg, adx_next, ady_next;
    logic               dxneg_reg, dyneg_reg;
    logic        [16:0] total2_reg;
    logic        [15:0] m1_2_reg, m2_2_reg;
    ecr_pkg::vel_t      vel2_reg;

    // Stage 3 registers
    logic               vld3_reg;
    ecr_pkg::geom_t     geom_reg, geom_next;
    logic        [65:0] d2_next;

    // Take differences of positions and velocities, sum radii and masses
    always_comb begin
        dx_next  = $signed({in_item.second_pos_x[31], in_item.second_pos_x})
                 - $signed({in_item.first_pos_x[31], in_item.first_pos_x});
        dy_next  = $signed({in_item.second_pos_y[31], in_item.second_pos_y})
                 - $signed({in_item.first_pos_y[31], in_item.first_pos_y});
        dvx_next = $signed({in_item.first_vel_x[31], in_item.first_vel_x})
                 - $signed({in_item.second_vel_x[31], in_item.second_vel_x});
        dvy_next = $signed({in_item.first_vel_y[31], in_item.first_vel_y})
                 - $signed({in_item.second_vel_y[31], in_item.second_vel_y});
        rs_next     = {1'b0, in_item.first_radius} + {1'b0, in_item.second_radius};
        total1_next = {1'b0, in_item.first_mass} + {1'b0, in_item.second_mass};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx_reg       <= dx_next;
            dy_reg       <= dy_next;
            dvx_reg      <= dvx_next;
            dvy_reg      <= dvy_next;
            rs_reg       <= rs_next;
            total1_reg   <= total1_next;
            m1_1_reg     <= in_item.first_mass;
            m2_1_reg     <= in_item.second_mass;
            vel1_reg.v1x <= in_item.first_vel_x;
            vel1_reg.v1y <= in_item.first_vel_y;
            vel1_reg.v2x <= in_item.second_vel_x;
            vel1_reg.v2y <= in_item.second_vel_y;
        end
    end

    // Square the offsets and radius sum, form the dot product terms
    always_comb begin
        sqx_full = dx_reg * dx_reg;
        sqy_full = dy_reg * dy_reg;
        pdx_next = dvx_reg * dx_reg;
        pdy_next = dvy_reg * dy_reg;
        rs2_next = rs_reg * rs_reg;
        adx_next = dx_reg[32] ? (33'd0 - dx_reg) : dx_reg;
        ady_next = dy_reg[32] ? (33'd0 - dy_reg) : dy_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld2_reg <= 1'b0;
        end else if (en) begin
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg    <= sqx_full[64:0];
            sqy_reg    <= sqy_full[64:0];
            pdx_reg    <= pdx_next;
            pdy_reg    <= pdy_next;
            rs2_reg    <= rs2_next;
            adx_reg    <= adx_next;
            ady_reg    <= ady_next;
            dxneg_reg  <= dx_reg[32];
            dyneg_reg  <= dy_reg[32];
            total2_reg <= total1_reg;
            m1_2_reg   <= m1_1_reg;
            m2_2_reg   <= m2_1_reg;
            vel2_reg   <= vel1_reg;
        end
    end

    // Sum the squares and dot terms, test overlap
    always_comb begin
        d2_next             = {1'b0, sqx_reg} + {1'b0, sqy_reg};
        geom_next.d2        = d2_next;
        geom_next.dot       = {pdx_reg[65], pdx_reg} + {pdy_reg[65], pdy_reg};
        geom_next.side.vel  = vel2_reg;
        geom_next.side.hit  = (d2_next <= {2'b00, rs2_reg}) && (d2_next != 66'd0)
                            && (total2_reg != 17'd0);
        geom_next.adx       = adx_reg;
        geom_next.ady       = ady_reg;
        geom_next.dxneg     = dxneg_reg;
        geom_next.dyneg     = dyneg_reg;
        geom_next.m1        = m1_2_reg;
        geom_next.m2        = m2_2_reg;
        geom_next.total     = total2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld3_reg <= 1'b0;
        end else if (en) begin
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            geom_reg <= geom_next;
        end
    end

    assign out_valid = vld3_reg;
    assign out_geom  = geom_reg;

endmodule

>>> hw/rtl/ecr_prod.sv
// Product stages: mass-weighted numerators and denominator for each correction lane.
module ecr_prod (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  ecr_pkg::geom_t  in_geom,
    output logic            out_valid,
    output ecr_pkg::lanes_t out_lanes,
    output ecr_pkg::side_t  out_side
);

    // Stage 4: magnitude of the dot product, denominator partials
    logic           vld4_reg;
    ecr_pkg::side_t side4_reg;
    logic           dneg4_reg, xneg4_reg, yneg4_reg;
    logic [65:0]    absd4_reg;
    logic [66:0]    dot_mag;
    logic [49:0]    dlo4_reg, dhi4_reg, dlo_next, dhi_next;
    logic [16:0]    c1_4_reg, c2_4_reg;
    logic [32:0]    adx4_reg, ady4_reg;

    // Stage 5: denominator, coefficient partials
    logic           vld5_reg;
    ecr_pkg::side_t side5_reg;
    logic           dneg5_reg, xneg5_reg, yneg5_reg;
    logic [82:0]    den5_reg, den_next;
    logic [49:0]    a1lo5_reg, a1hi5_reg, a2lo5_reg, a2hi5_reg;
    logic [49:0]    a1lo_next, a1hi_next, a2lo_next, a2hi_next;
    logic [32:0]    adx5_reg, ady5_reg;

    // Stage 6: coefficient products
    logic           vld6_reg;
    ecr_pkg::side_t side6_reg;
    logic           dneg6_reg, xneg6_reg, yneg6_reg;
    logic [82:0]    den6_reg;
    logic [82:0]    a1_6_reg, a2_6_reg, a1_next, a2_next;
    logic [32:0]    adx6_reg, ady6_reg;

    // Stage 7: axis partial products, three slices per lane
    logic           vld7_reg;
    ecr_pkg::side_t side7_reg;
    logic           dneg7_reg, xneg7_reg, yneg7_reg;
    logic [82:0]    den7_reg;
    logic [60:0]    p7_reg  [0:ecr_pkg::LANES-1][0:2];
    logic [60:0]    p7_next [0:ecr_pkg::LANES-1][0:2];
    logic [83:0]    a_sel;
    logic [32:0]    ax_sel;

    // Stage 8: lane numerators
    logic           vld8_reg;
    ecr_pkg::side_t side8_reg;
    logic           dneg8_reg, xneg8_reg, yneg8_reg;
    logic [82:0]    den8_reg;
    logic [115:0]   num8_reg  [0:ecr_pkg::LANES-1];
    logic [115:0]   num8_next [0:ecr_pkg::LANES-1];

    // Stage 9: rounding numerator and doubled denominator
    logic            vld9_reg;
    ecr_pkg::side_t  side9_reg;
    ecr_pkg::lanes_t lanes9_reg, lanes9_next;

    // Take the dot magnitude, split the denominator product
    always_comb begin
        dot_mag  = in_geom.dot[66] ? (67'd0 - in_geom.dot) : in_geom.dot;
        dlo_next = in_geom.d2[32:0] * in_geom.total;
        dhi_next = in_geom.d2[65:33] * in_geom.total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
            vld7_reg <= 1'b0;
            vld8_reg <= 1'b0;
            vld9_reg <= 1'b0;
        end else if (en) begin
            vld4_reg <= in_valid;
            vld5_reg <= vld4_reg;
            vld6_reg <= vld5_reg;
            vld7_reg <= vld6_reg;
            vld8_reg <= vld7_reg;
            vld9_reg <= vld8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side4_reg <= in_geom.side;
            dneg4_reg <= in_geom.dot[66];
            xneg4_reg <= in_geom.dxneg;
            yneg4_reg <= in_geom.dyneg;
            absd4_reg <= dot_mag[65:0];
            dlo4_reg  <= dlo_next;
            dhi4_reg  <= dhi_next;
            c1_4_reg  <= {in_geom.m1, 1'b0};
            c2_4_reg  <= {in_geom.m2, 1'b0};
            adx4_reg  <= in_geom.adx;
            ady4_reg  <= in_geom.ady;
        end
    end

    // Join the denominator, split the coefficient products
    always_comb begin
        den_next  = {dhi4_reg, 33'd0} + {33'd0, dlo4_reg};
        a1lo_next = absd4_reg[32:0] * c1_4_reg;
        a1hi_next = absd4_reg[65:33] * c1_4_reg;
        a2lo_next = absd4_reg[32:0] * c2_4_reg;
        a2hi_next = absd4_reg[65:33] * c2_4_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side5_reg <= side4_reg;
            dneg5_reg <= dneg4_reg;
            xneg5_reg <= xneg4_reg;
            yneg5_reg <= yneg4_reg;
            den5_reg  <= den_next;
            a1lo5_reg <= a1lo_next;
            a1hi5_reg <= a1hi_next;
            a2lo5_reg <= a2lo_next;
            a2hi5_reg <= a2hi_next;
            adx5_reg  <= adx4_reg;
            ady5_reg  <= ady4_reg;
        end
    end

    // Join the coefficient products
    always_comb begin
        a1_next = {a1hi5_reg, 33'd0} + {33'd0, a1lo5_reg};
        a2_next = {a2hi5_reg, 33'd0} + {33'd0, a2lo5_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side6_reg <= side5_reg;
            dneg6_reg <= dneg5_reg;
            xneg6_reg <= xneg5_reg;
            yneg6_reg <= yneg5_reg;
            den6_reg  <= den5_reg;
            a1_6_reg  <= a1_next;
            a2_6_reg  <= a2_next;
            adx6_reg  <= adx5_reg;
            ady6_reg  <= ady5_reg;
        end
    end

    // Multiply each coefficient product by the axis magnitude in slices
    always_comb begin
        a_sel  = '0;
        ax_sel = '0;
        for (int l = 0; l < ecr_pkg::LANES; l++) begin
            a_sel  = (l < 2) ? {1'b0, a2_6_reg} : {1'b0, a1_6_reg};
            ax_sel = (l % 2 == 1) ? ady6_reg : adx6_reg;
            p7_next[l][0] = a_sel[27:0] * ax_sel;
            p7_next[l][1] = a_sel[55:28] * ax_sel;
            p7_next[l][2] = a_sel[83:56] * ax_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side7_reg <= side6_reg;
            dneg7_reg <= dneg6_reg;
            xneg7_reg <= xneg6_reg;
            yneg7_reg <= yneg6_reg;
            den7_reg  <= den6_reg;
            p7_reg    <= p7_next;
        end
    end

    // Sum the slices into each numerator
    always_comb begin
        for (int l = 0; l < ecr_pkg::LANES; l++) begin
            num8_next[l] = 116'(p7_reg[l][0]) + (116'(p7_reg[l][1]) << 28)
                         + (116'(p7_reg[l][2]) << 56);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side8_reg <= side7_reg;
            dneg8_reg <= dneg7_reg;
            xneg8_reg <= xneg7_reg;
            yneg8_reg <= yneg7_reg;
            den8_reg  <= den7_reg;
            num8_reg  <= num8_next;
        end
    end

    // Add half the divisor for round-to-nearest, attach the sign
    always_comb begin
        for (int l = 0; l < ecr_pkg::LANES; l++) begin
            lanes9_next[l].num = {num8_reg[l][114:0], 1'b0} + {33'd0, den8_reg};
            lanes9_next[l].den = {den8_reg, 1'b0};
            lanes9_next[l].neg = dneg8_reg ^ ((l % 2 == 1) ? yneg8_reg : xneg8_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side9_reg  <= side8_reg;
            lanes9_reg <= lanes9_next;
        end
    end

    assign out_valid = vld9_reg;
    assign out_lanes = lanes9_reg;
    assign out_side  = side9_reg;

endmodule

>>> hw/rtl/ecr_div.sv
// Pipelined restoring divider for one lane, one quotient bit per stage, capped and signed.
module ecr_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  ecr_pkg::lane_t     in_lane,
    output logic               out_valid,
    output logic signed [41:0] out_corr
);

    localparam int S = ecr_pkg::DIV_STEPS;

    logic              vld_reg [0:S];
    logic              ovf_reg [0:S];
    logic              neg_reg [0:S];
    logic [83:0]       rem_reg [0:S];
    logic [83:0]       den_reg [0:S];
    logic [40:0]       low_reg [0:S];
    logic [40:0]       quo_reg [0:S];
    logic [83:0]       rem0_next;

    logic              cvld_reg;
    logic signed [41:0] corr_reg, corr_next;
    logic [40:0]       mag;

    // Flag quotients that cannot fit, load the top numerator bits
    assign rem0_next = {9'd0, in_lane.num[115:41]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= (rem0_next >= in_lane.den);
            neg_reg[0] <= in_lane.neg;
            rem_reg[0] <= rem0_next;
            den_reg[0] <= in_lane.den;
            low_reg[0] <= in_lane.num[40:0];
            quo_reg[0] <= '0;
        end
    end

    // Resolve one quotient bit per stage
    for (genvar k = 1; k <= S; k++) begin : g_step
        logic [84:0] trial;
        logic [84:0] diff;
        logic        ge;

        always_comb begin
            trial = {rem_reg[k-1], low_reg[k-1][40]};
            diff  = trial - {1'b0, den_reg[k-1]};
            ge    = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ovf_reg[k] <= ovf_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                rem_reg[k] <= ge ? diff[83:0] : trial[83:0];
                low_reg[k] <= {low_reg[k-1][39:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][39:0], ge};
            end
        end
    end

    // Cap the magnitude and apply the sign
    always_comb begin
        mag = (ovf_reg[S] || (quo_reg[S] > ecr_pkg::QCAP)) ? ecr_pkg::QCAP : quo_reg[S];
        corr_next = neg_reg[S] ? (42'sd0 - $signed({1'b0, mag})) : $signed({1'b0, mag});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cvld_reg <= 1'b0;
        end else if (en) begin
            cvld_reg <= vld_reg[S];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            corr_reg <= corr_next;
        end
    end

    assign out_valid = cvld_reg;
    assign out_corr  = corr_reg;

    // The partial remainder stays below the divisor when no overflow was flagged
    assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[S] && !ovf_reg[S] |-> rem_reg[S] < den_reg[S])
        else $error("divider remainder not reduced");

    // The correction never exceeds the cap in magnitude
    assert property (@(posedge aclk) disable iff (!aresetn)
        cvld_reg |-> (corr_reg[41] ? (42'd0 - corr_reg) : corr_reg) <= {1'b0, ecr_pkg::QCAP})
        else $error("correction above cap");

endmodule

>>> hw/rtl/elastic_disc_collision_resolver_top.sv
// Top level of the disc collision resolver: handshake, lanes, side delay and output stage.
// Pipeline: geometry, product, divider and output stages in that order, from request acceptance
// to result valid; the 41-step pipelined divider sets the depth.
// Throughput: one request per cycle; a held result stalls every stage together.
// Reset: aresetn low clears all valid bits; data registers are not reset.
module elastic_disc_collision_resolver_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_pos_x, first_pos_y, first_vel_x, first_vel_y, first_mass, first_radius,
    // second_pos_x, second_pos_y, second_vel_x, second_vel_y, second_mass, second_radius
    input  logic [351:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // hit, new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
    output logic [135:0] m_tdata
);

    localparam int L = ecr_pkg::DIV_LAT;

    logic                en;
    ecr_pkg::in_t        in_item;
    logic                geom_vld;
    ecr_pkg::geom_t      geom;
    logic                prod_vld;
    ecr_pkg::lanes_t     lanes;
    ecr_pkg::side_t      prod_side;
    logic [ecr_pkg::LANES-1:0] div_vld;
    logic signed [41:0]  corr [0:ecr_pkg::LANES-1];

    logic                side_vld_reg [0:L-1];
    ecr_pkg::side_t      side_reg     [0:L-1];

    logic                m_valid_reg;
    ecr_pkg::out_t       m_data_reg, m_data_next;
    ecr_pkg::vel_t       vel;

    // Advance the whole pipeline unless a result is held at the output
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign in_item  = ecr_pkg::in_t'(s_tdata[ecr_pkg::IN_BITS-1:0]);

    ecr_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_item   (in_item),
        .out_valid (geom_vld),
        .out_geom  (geom)
    );

    ecr_prod u_prod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geom_vld),
        .in_geom   (geom),
        .out_valid (prod_vld),
        .out_lanes (lanes),
        .out_side  (prod_side)
    );

    for (genvar l = 0; l < ecr_pkg::LANES; l++) begin : g_lane
        ecr_div u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (prod_vld),
            .in_lane   (lanes[l]),
            .out_valid (div_vld[l]),
            .out_corr  (corr[l])
        );
    end

    // Delay velocities and hit alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < L; i++) begin
                side_vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            side_vld_reg[0] <= prod_vld;
            for (int i = 1; i < L; i++) begin
                side_vld_reg[i] <= side_vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= prod_side;
            for (int i = 1; i < L; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Apply corrections with saturation, or pass velocities when there is no hit
    always_comb begin
        vel = side_reg[L-1].vel;
        m_data_next.hit = side_reg[L-1].hit;
        if (side_reg[L-1].hit) begin
            m_data_next.new_first_vel_x = ecr_pkg::sat32(
                $signed({{11{vel.v1x[31]}}, vel.v1x}) - $signed({corr[0][41], corr[0]}));
            m_data_next.new_first_vel_y = ecr_pkg::sat32(
                $signed({{11{vel.v1y[31]}}, vel.v1y}) - $signed({corr[1][41], corr[1]}));
            m_data_next.new_second_vel_x = ecr_pkg::sat32(
                $signed({{11{vel.v2x[31]}}, vel.v2x}) + $signed({corr[2][41], corr[2]}));
            m_data_next.new_second_vel_y = ecr_pkg::sat32(
                $signed({{11{vel.v2y[31]}}, vel.v2y}) + $signed({corr[3][41], corr[3]}));
        end else begin
            m_data_next.new_first_vel_x  = vel.v1x;
            m_data_next.new_first_vel_y  = vel.v1y;
            m_data_next.new_second_vel_x = vel.v2x;
            m_data_next.new_second_vel_y = vel.v2y;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= div_vld[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(ecr_pkg::OUT_TDATA - ecr_pkg::OUT_BITS){1'b0}}, m_data_reg};

    // Side data stays aligned with the divider lanes
    assert property (@(posedge aclk) disable iff (!aresetn)
        side_vld_reg[L-1] == div_vld[0])
        else $error("side delay out of step with divider");

    // All divider lanes deliver together
    assert property (@(posedge aclk) disable iff (!aresetn)
        (div_vld == '0) || (div_vld == '1))
        else $error("divider lanes disagree");

endmodule

>>> bench/ecr_checker.sv
// Watches both channels of the collision resolver, predicts each result and compares.
module ecr_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [351:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [135:0] m_tdata,
    output int           pending,
    output int           fail_count
);

    localparam logic [127:0] CORR_CAP = 128'h1 << 40;

    ecr_pkg::out_t expected_results[$];

    // Rounded, capped, signed share of the normal component along one axis
    function automatic longint axis_share(logic [127:0] absdot, logic dotneg,
                                          logic [127:0] coef, longint axis,
                                          logic [127:0] den);
        logic [127:0] mag;
        logic [127:0] num;
        logic [127:0] q;
        mag = (axis < 0) ? 128'(-axis) : 128'(axis);
        num = absdot * coef * mag;
        q = (2 * num + den) / (2 * den);
        if (q > CORR_CAP) begin
            q = CORR_CAP;
        end
        return (dotneg != (axis < 0)) ? -longint'(q) : longint'(q);
    endfunction

    // Clamp to the signed 32 bit range
    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Resolve one pair of discs
    function automatic ecr_pkg::out_t resolve_pair(ecr_pkg::in_t r);
        ecr_pkg::out_t o;
        longint v1x, v1y, v2x, v2y, dx, dy, m1, m2, total;
        logic [127:0] adx, ady, d2, rs, absdot, den;
        logic signed [127:0] dvx, dvy, sdx, sdy, dot;
        logic dotneg;
        v1x = longint'(r.first_vel_x);
        v1y = longint'(r.first_vel_y);
        v2x = longint'(r.second_vel_x);
        v2y = longint'(r.second_vel_y);
        dx = longint'(r.second_pos_x) - longint'(r.first_pos_x);
        dy = longint'(r.second_pos_y) - longint'(r.first_pos_y);
        m1 = longint'(r.first_mass);
        m2 = longint'(r.second_mass);
        total = m1 + m2;
        adx = (dx < 0) ? 128'(-dx) : 128'(dx);
        ady = (dy < 0) ? 128'(-dy) : 128'(dy);
        d2 = adx * adx + ady * ady;
        rs = 128'(r.first_radius) + 128'(r.second_radius);
        o.hit = (d2 <= rs * rs) && (d2 != 0) && (total != 0);
        o.new_first_vel_x = r.first_vel_x;
        o.new_first_vel_y = r.first_vel_y;
        o.new_second_vel_x = r.second_vel_x;
        o.new_second_vel_y = r.second_vel_y;
        if (o.hit) begin
            dvx = v1x - v2x;
            dvy = v1y - v2y;
            sdx = dx;
            sdy = dy;
            dot = dvx * sdx + dvy * sdy;
            dotneg = dot < 0;
            absdot = dotneg ? -dot : dot;
            den = d2 * 128'(total);
            o.new_first_vel_x = clamp32(v1x - axis_share(absdot, dotneg, 2 * m2, dx, den));
            o.new_first_vel_y = clamp32(v1y - axis_share(absdot, dotneg, 2 * m2, dy, den));
            o.new_second_vel_x = clamp32(v2x + axis_share(absdot, dotneg, 2 * m1, dx, den));
            o.new_second_vel_y = clamp32(v2y + axis_share(absdot, dotneg, 2 * m1, dy, den));
        end
        return o;
    endfunction

    assign pending = expected_results.size();

    // Queue predictions on accepted requests, compare on accepted results
    always @(posedge aclk) begin
        ecr_pkg::out_t got;
        ecr_pkg::out_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results = {expected_results,
                    resolve_pair(ecr_pkg::in_t'(s_tdata[ecr_pkg::IN_BITS-1:0]))};
            end
            if (m_tvalid && m_tready) begin
                got = ecr_pkg::out_t'(m_tdata[ecr_pkg::OUT_BITS-1:0]);
                if (expected_results.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("unexpected result %h", got);
                    end
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got.hit !== want.hit || got.new_first_vel_x !== want.new_first_vel_x
                        || got.new_first_vel_y !== want.new_first_vel_y
                        || got.new_second_vel_x !== want.new_second_vel_x
                        || got.new_second_vel_y !== want.new_second_vel_y) begin
                        if (fail_count < 10) begin
                            $display("mismatch: expected hit=%0d v1=(%h,%h) v2=(%h,%h)",
                                     want.hit, want.new_first_vel_x, want.new_first_vel_y,
                                     want.new_second_vel_x, want.new_second_vel_y);
                            $display("          actual   hit=%0d v1=(%h,%h) v2=(%h,%h)",
                                     got.hit, got.new_first_vel_x, got.new_first_vel_y,
                                     got.new_second_vel_x, got.new_second_vel_y);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

>>> bench/tb.sv
// Stimulus and verdict for the disc collision resolver.
module tb;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [351:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    int           pending;
    int           fail_count;
    int           sent = 0;

    elastic_disc_collision_resolver_top uut (.*);

    ecr_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .pending(pending), .fail_count(fail_count)
    );

    always #10 aclk = ~aclk;

    // Half the time no gap, otherwise mostly short gaps and a few long ones
    function automatic int gap_len();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 50) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random signed value of random magnitude, sometimes the full range
    function automatic logic [31:0] rand_val();
        int k;
        logic [31:0] v;
        if ($urandom_range(0, 4) == 0) return $urandom;
        k = $urandom_range(0, 30);
        v = $urandom & ((32'h1 << k) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Offer one request and hold it until accepted, then sometimes idle a while
    task automatic send_pair(ecr_pkg::in_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, r};
        do @(posedge aclk); while (!s_tready);
        sent++;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic ecr_pkg::in_t make_pair(logic [31:0] p1x, logic [31:0] p1y,
                                               logic [31:0] dx, logic [31:0] dy,
                                               logic [31:0] v1x, logic [31:0] v1y,
                                               logic [31:0] v2x, logic [31:0] v2y,
                                               logic [15:0] m1, logic [15:0] m2,
                                               logic [30:0] r1, logic [30:0] r2);
        ecr_pkg::in_t r;
        r.first_pos_x = p1x;
        r.first_pos_y = p1y;
        r.second_pos_x = p1x + dx;
        r.second_pos_y = p1y + dy;
        r.first_vel_x = v1x;
        r.first_vel_y = v1y;
        r.second_vel_x = v2x;
        r.second_vel_y = v2y;
        r.first_mass = m1;
        r.second_mass = m2;
        r.first_radius = r1;
        r.second_radius = r2;
        return r;
    endfunction

    // Nearby discs with radii near their spacing, so most pairs collide
    function automatic ecr_pkg::in_t random_pair();
        int k;
        logic [31:0] dx, dy, span;
        logic [15:0] m1, m2;
        logic [351:0] raw;
        ecr_pkg::in_t r;
        if ($urandom_range(0, 9) == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom, $urandom, $urandom, $urandom};
            r = raw[ecr_pkg::IN_BITS-1:0];
            return r;
        end
        k = $urandom_range(1, 30);
        span = 32'h1 << k;
        dx = $urandom & (span - 1);
        dy = $urandom & (span - 1);
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        m1 = 16'($urandom_range(1, 65535));
        m2 = ($urandom_range(0, 3) == 0) ? m1 : 16'($urandom_range(1, 65535));
        r = make_pair($urandom, $urandom, dx, dy, rand_val(), rand_val(), rand_val(),
                      rand_val(), m1, m2, 31'($urandom_range(0, span)),
                      31'($urandom_range(0, span)));
        return r;
    endfunction

    // Result side: random stalls, one long hold-off while requests keep coming
    initial begin
        bit long_done;
        int gap;
        long_done = 0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!long_done && sent >= 200) begin
                long_done = 1;
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            gap = gap_len();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("elastic_disc_collision_resolver_top verification failed");
        $finish;
    end

    // Request side and verdict
    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Extremes and special cases
        send_pair(make_pair(0, 0, 100, 0, 32'h10000, 0, 0, 0, 256, 256, 0, 10));
        send_pair(make_pair(0, 0, 100, 0, 32'h10000, 0, 0, 0, 256, 256, 0, 99));
        send_pair(make_pair(5, 7, 3, 4, 32'h30000, 32'hFFFF0000, 32'hFFFE0000, 32'h10000,
                            512, 256, 2, 3));
        send_pair(make_pair(5, 7, 3, 4, 32'h30000, 0, 0, 0, 512, 256, 2, 2));
        send_pair(make_pair(1000, 1000, 0, 0, 32'h12345, 32'h777, 32'h9, 32'h5,
                            100, 200, 50, 50));
        send_pair(make_pair(0, 0, 10, 10, 32'h20000, 32'h1000, 32'hFFFF0000, 0,
                            0, 0, 100, 100));
        send_pair(make_pair(0, 0, 10, 10, 32'h20000, 32'h1000, 32'hFFFF0000, 0,
                            0, 300, 100, 100));
        send_pair(make_pair(0, 0, 10, 10, 32'h20000, 32'h1000, 32'hFFFF0000, 0,
                            300, 0, 100, 100));
        send_pair(make_pair(0, 0, 1, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000,
                            32'h80000000, 16'hFFFF, 1, 1, 1));
        send_pair(make_pair(0, 0, 1, 0, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                            32'h7FFFFFFF, 1, 16'hFFFF, 1, 1));
        send_pair(make_pair(32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF,
                            32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF,
                            16'hFFFF, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
        send_pair(make_pair(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000001,
                            32'hFFFFFFFF, 1, 0, 32'hFFFFFFFF, 1, 1,
                            31'h7FFFFFFF, 31'h7FFFFFFF));
        send_pair(make_pair(32'h7FFFFFFF, 32'h80000000, 32'h80000001, 32'h7FFFFFFF,
                            32'h55555555, 32'hAAAAAAAA, 32'hAAAAAAAA, 32'h55555555,
                            16'h5555, 16'hAAAA, 31'h55555555, 31'h2AAAAAAA));
        send_pair(make_pair(0, 0, 32'h40000000, 32'h40000000, 32'h7FFFFFFF, 0,
                            32'h80000000, 0, 1, 1, 0, 31'h7FFFFFFF));
        send_pair(make_pair(32'h0FF00000, 0, 32'hFFFFFFFF, 0, 32'h12345678, 32'h7654321,
                            0, 0, 16'h8000, 16'h0001, 31'h10000, 0));
        // Drain before the random part
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (60) @(posedge aclk);
        repeat (500) send_pair(random_pair());
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (100) @(posedge aclk);
        if (fail_count == 0) begin
            $display("elastic_disc_collision_resolver_top verification clean");
        end else begin
            $display("elastic_disc_collision_resolver_top verification failed");
        end
        $finish;
    end

endmodule
